/* src/aes_pkg.sv */
package aes_pkg;

   localparam int unsigned Rounds = 10;
   localparam int unsigned RegCount = 2;

   typedef logic [127:0] block_type;

   typedef enum logic [0:0] {
      ACTION_ENCRYPT = 1'b0,
      ACTION_DECRYPT = 1'b1
   } action_type;

   typedef enum logic [0:0] {
      REG_KEY_UPPER = 1'b0,
      REG_KEY_LOWER = 1'b1
   } reg_index_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam logic [7:0] INV_SBOX [256] = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
   };

   localparam logic [7:0] RCON [10] = '{
      8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
   };

   function automatic logic [7:0] xtime(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   // Forward or inverse MixColumns on one column, byte 0 in the top bits.
   function automatic logic [31:0] mix_col(input logic [31:0] col, input logic inv);
      logic [7:0] a [4];
      logic [7:0] x2 [4];
      logic [7:0] x4 [4];
      logic [7:0] x8 [4];
      logic [7:0] m2 [4];
      logic [7:0] m3 [4];
      logic [7:0] m9 [4];
      logic [7:0] mb [4];
      logic [7:0] md [4];
      logic [7:0] me [4];
      logic [31:0] res;
      for (int k = 0; k < 4; k++) begin
         a[k] = col[31-8*k -: 8];
         x2[k] = xtime(a[k]);
         x4[k] = xtime(x2[k]);
         x8[k] = xtime(x4[k]);
         m2[k] = x2[k];
         m3[k] = x2[k] ^ a[k];
         m9[k] = x8[k] ^ a[k];
         mb[k] = x8[k] ^ x2[k] ^ a[k];
         md[k] = x8[k] ^ x4[k] ^ a[k];
         me[k] = x8[k] ^ x4[k] ^ x2[k];
      end
      for (int r = 0; r < 4; r++) begin
         if (inv) begin
            res[31-8*r -: 8] = me[r] ^ mb[(r+1)%4] ^ md[(r+2)%4] ^ m9[(r+3)%4];
         end else begin
            res[31-8*r -: 8] = m2[r] ^ m3[(r+1)%4] ^ a[(r+2)%4] ^ a[(r+3)%4];
         end
      end
      return res;
   endfunction

endpackage

/* src/aes_stream_if.sv */
interface aes_stream_if #(parameter int unsigned Width = 128);
   logic             valid;
   logic             ready;
   logic [Width-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

/* src/aes128_block_cipher.sv */
// AES-128 block cipher, encrypt or decrypt chosen per transaction. The key is
// written as two 64-bit registers (index 0 = key bytes 0..7, index 1 = bytes
// 8..15). After each key write the eleven round keys are expanded one per
// cycle, followed by the nine decryption keys passed through InvMixColumns; allow
// 21 cycles after the last key write before the first request. The datapath is
// an 11-stage pipeline (initial key add plus one register per round) that
// accepts one block per cycle except while it stalls: the whole pipeline
// stalls when the response is not taken.
module aes128_block_cipher (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_write_enable,
   input  logic [0:0]    csr_index,
   input  logic [63:0]   csr_write_data,
   aes_stream_if.sink    req,
   aes_stream_if.source  rsp
);
   import aes_pkg::*;

   // Request payload: {action, block_upper, block_lower}.
   logic       req_action;
   block_type  req_block;
   assign req_action = req.data[128];
   assign req_block  = req.data[127:0];

   // Key registers.
   logic [63:0] key_upper_ff;
   logic [63:0] key_lower_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         key_upper_ff <= '0;
         key_lower_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (reg_index_type'(csr_index))
            REG_KEY_UPPER: key_upper_ff <= csr_write_data;
            REG_KEY_LOWER: key_lower_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Key expansion sequencer: one round key per cycle, then one
   // InvMixColumns key per cycle.
   logic       exp_busy_ff;
   logic [4:0] exp_step_ff;
   logic       exp_start_ff;
   block_type  exp_word_ff;
   block_type  enc_key_ff [11];
   block_type  dec_key_ff [11];
   block_type  exp_next;
   logic [31:0] rot_word;
   logic [3:0]  rnd_idx;
   logic [3:0]  inv_idx;
   block_type   inv_key;

   always_comb begin
      rnd_idx  = exp_step_ff[3:0];
      rot_word = {exp_word_ff[23:0], exp_word_ff[31:24]};
      exp_next[127:96] = exp_word_ff[127:96] ^
         {SBOX[rot_word[31:24]] ^ RCON[rnd_idx - 4'd1], SBOX[rot_word[23:16]],
          SBOX[rot_word[15:8]], SBOX[rot_word[7:0]]};
      exp_next[95:64] = exp_word_ff[95:64] ^ exp_next[127:96];
      exp_next[63:32] = exp_word_ff[63:32] ^ exp_next[95:64];
      exp_next[31:0]  = exp_word_ff[31:0]  ^ exp_next[63:32];
      inv_idx = exp_step_ff[3:0] - 4'd10;
      for (int c = 0; c < 4; c++) begin
         inv_key[127-32*c -: 32] = mix_col(enc_key_ff[inv_idx][127-32*c -: 32], 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_busy_ff  <= 1'b0;
         exp_start_ff <= 1'b0;
         exp_step_ff  <= '0;
      end else begin
         exp_start_ff <= csr_write_enable;
         if (exp_start_ff) begin
            exp_busy_ff <= 1'b1;
            exp_step_ff <= 5'd1;
         end else if (exp_busy_ff) begin
            if (exp_step_ff == 5'd19) begin
               exp_busy_ff <= 1'b0;
            end
            exp_step_ff <= exp_step_ff + 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (exp_start_ff) begin
         exp_word_ff   <= {key_upper_ff, key_lower_ff};
         enc_key_ff[0] <= {key_upper_ff, key_lower_ff};
         dec_key_ff[0] <= {key_upper_ff, key_lower_ff};
      end else if (exp_busy_ff) begin
         if (exp_step_ff <= 5'd10) begin
            exp_word_ff         <= exp_next;
            enc_key_ff[rnd_idx] <= exp_next;
            if (exp_step_ff == 5'd10) begin
               dec_key_ff[10] <= exp_next;
            end
         end else begin
            dec_key_ff[inv_idx] <= inv_key;
         end
      end
   end

   // Pipeline control: everything moves when the output slot is free or taken.
   logic advance;
   logic v_ff [11];
   logic d_ff [11];
   block_type s_ff [11];

   assign advance   = !rsp.valid || rsp.ready;
   assign req.ready = advance;

   // Stage 0: initial key add.
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (advance) begin
         v_ff[0] <= req.valid;
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         d_ff[0] <= req_action;
         s_ff[0] <= req_block ^ (req_action ? dec_key_ff[10] : enc_key_ff[0]);
      end
   end

   // Rounds 1 to 10; decryption uses keys in reverse order.
   for (genvar g = 1; g <= 10; g++) begin : g_round
      aes_round #(.Last(g == 10)) u_round (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .valid_in  (v_ff[g-1]),
         .dec_in    (d_ff[g-1]),
         .state_in  (s_ff[g-1]),
         .enc_key   (enc_key_ff[g]),
         .dec_key   (dec_key_ff[10-g]),
         .valid_out (v_ff[g]),
         .dec_out   (d_ff[g]),
         .state_out (s_ff[g])
      );
   end

   assign rsp.valid = v_ff[10];
   assign rsp.data  = s_ff[10];
endmodule

/* src/aes_round.sv */
// One cipher round: substitution, row shift, optional column mix and key add.
// Encryption: SubBytes, ShiftRows, MixColumns, AddRoundKey.
// Decryption (equivalent inverse): InvSubBytes, InvShiftRows, InvMixColumns,
// AddRoundKey with a key already passed through InvMixColumns.
module aes_round #(
   parameter bit Last = 1'b0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  valid_in,
   input  logic                  dec_in,
   input  aes_pkg::block_type    state_in,
   input  aes_pkg::block_type    enc_key,
   input  aes_pkg::block_type    dec_key,
   output logic                  valid_out,
   output logic                  dec_out,
   output aes_pkg::block_type    state_out
);
   import aes_pkg::*;

   logic       valid_ff;
   logic       dec_ff;
   block_type  state_ff;
   block_type  state_in_next;
   logic [7:0] sub [16];
   logic [7:0] shf [16];
   block_type  mixed;

   // Byte substitution.
   always_comb begin
      for (int i = 0; i < 16; i++) begin
         sub[i] = dec_in ? INV_SBOX[state_in[127-8*i -: 8]] : SBOX[state_in[127-8*i -: 8]];
      end
   end

   // Row shift; byte i sits at row i%4, column i/4.
   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            if (dec_in) begin
               shf[r + 4*((c + r) % 4)] = sub[r + 4*c];
            end else begin
               shf[r + 4*c] = sub[r + 4*((c + r) % 4)];
            end
         end
      end
   end

   // Column mix and key add.
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         if (Last) begin
            mixed[127-32*c -: 32] = {shf[4*c], shf[4*c+1], shf[4*c+2], shf[4*c+3]};
         end else begin
            mixed[127-32*c -: 32] =
               mix_col({shf[4*c], shf[4*c+1], shf[4*c+2], shf[4*c+3]}, dec_in);
         end
      end
      state_in_next = mixed ^ (dec_in ? dec_key : enc_key);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dec_ff   <= dec_in;
         state_ff <= state_in_next;
      end
   end

   assign valid_out = valid_ff;
   assign dec_out   = dec_ff;
   assign state_out = state_ff;
endmodule

/* sim/tb.sv */
module tb;
   import aes_pkg::*;

   typedef struct {
      action_type act;
      block_type  blk;
      int         gap;
      bit         drain;
   } cipher_job_type;

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [0:0]  csr_index;
   logic [63:0] csr_write_data;

   aes_stream_if #(.Width(129)) req_if ();
   aes_stream_if #(.Width(128)) rsp_if ();

   aes128_block_cipher u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req              (req_if),
      .rsp              (rsp_if)
   );

   cipher_job_type jobs_pending[$];
   block_type   cipher_expected[$];
   logic [63:0] key_hi;
   logic [63:0] key_lo;
   int          error_count;
   int          blocks_sent;
   int          blocks_checked;
   int          cycle_count;
   int          sender_gap_left;
   int          current_gap;
   int          receiver_hold;
   bit          long_hold_done;
   bit          sparse_gaps;

   // Clock generation.
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Multiply two bytes in GF(2^8).
   function automatic logic [7:0] gf_mult(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p;
      p = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) p ^= a;
         a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
      end
      return p;
   endfunction

   // Standard key expansion into eleven 128-bit round keys.
   function automatic void expand_round_keys(input logic [127:0] key,
                                             output logic [127:0] rk [11]);
      logic [31:0] w [44];
      logic [31:0] t;
      for (int i = 0; i < 4; i++) w[i] = key[127-32*i -: 32];
      for (int i = 4; i < 44; i++) begin
         t = w[i-1];
         if (i % 4 == 0) begin
            t = {t[23:0], t[31:24]};
            t = {SBOX[t[31:24]], SBOX[t[23:16]], SBOX[t[15:8]], SBOX[t[7:0]]};
            t ^= {RCON[i/4-1], 24'h0};
         end
         w[i] = w[i-4] ^ t;
      end
      for (int r = 0; r < 11; r++) rk[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
   endfunction

   // AES-128 forward or inverse cipher on one block; byte 0 sits in the top bits.
   function automatic block_type aes_transform(input action_type act, input block_type blk,
                                               input logic [127:0] key);
      logic [127:0] rk [11];
      logic [7:0] s [16];
      logic [7:0] t [16];
      logic [7:0] col [4];
      logic [7:0] coef [4];
      block_type res;
      expand_round_keys(key, rk);
      for (int i = 0; i < 16; i++) s[i] = blk[127-8*i -: 8];
      for (int step = 0; step <= 10; step++) begin
         int r;
         r = (act == ACTION_ENCRYPT) ? step : 10 - step;
         if (step > 0) begin
            // Substitution and row shift, forward or inverse.
            for (int row = 0; row < 4; row++)
               for (int c = 0; c < 4; c++) begin
                  if (act == ACTION_ENCRYPT)
                     t[row+4*c] = SBOX[s[row+4*((c+row)%4)]];
                  else
                     t[row+4*((c+row)%4)] = INV_SBOX[s[row+4*c]];
               end
            s = t;
            // Forward cipher mixes columns before the key add.
            if (act == ACTION_ENCRYPT && step != 10) begin
               coef = '{8'd2, 8'd3, 8'd1, 8'd1};
               for (int c = 0; c < 4; c++) begin
                  for (int k = 0; k < 4; k++) col[k] = s[4*c+k];
                  for (int row = 0; row < 4; row++) begin
                     s[4*c+row] = 8'h00;
                     for (int k = 0; k < 4; k++)
                        s[4*c+row] ^= gf_mult(col[k], coef[(k-row+4)%4]);
                  end
               end
            end
         end
         for (int i = 0; i < 16; i++) s[i] ^= rk[r][127-8*i -: 8];
         // Inverse cipher mixes columns after the key add, except on the first and last steps.
         if (act == ACTION_DECRYPT && step != 0 && step != 10) begin
            coef = '{8'd14, 8'd11, 8'd13, 8'd9};
            for (int c = 0; c < 4; c++) begin
               for (int k = 0; k < 4; k++) col[k] = s[4*c+k];
               for (int row = 0; row < 4; row++) begin
                  s[4*c+row] = 8'h00;
                  for (int k = 0; k < 4; k++)
                     s[4*c+row] ^= gf_mult(col[k], coef[(k-row+4)%4]);
               end
            end
         end
      end
      for (int i = 0; i < 16; i++) res[127-8*i -: 8] = s[i];
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      error_count++;
      $display("tb: mismatch on %s at cycle %0d: got %h, expected %h",
               what, cycle_count, got, want);
   endtask

   // Driver: offers queued blocks, honoring per-transaction gaps and drain points.
   always @(posedge clock) begin
      cipher_job_type job;
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.data <= '0;
         sender_gap_left <= 0;
      end else begin
         int gap_next;
         gap_next = sender_gap_left;
         if (req_if.valid && req_if.ready) begin
            cipher_expected.push_back(aes_transform(action_type'(req_if.data[128]),
                                                    req_if.data[127:0], {key_hi, key_lo}));
            blocks_sent++;
            gap_next = current_gap;
         end
         if (!req_if.valid || req_if.ready) begin
            if (gap_next > 0) begin
               req_if.valid <= 1'b0;
               gap_next--;
            end else if (jobs_pending.size() > 0 &&
                         (!jobs_pending[0].drain || cipher_expected.size() == 0)) begin
               job = jobs_pending.pop_front();
               req_if.valid <= 1'b1;
               req_if.data <= {job.act, job.blk};
               current_gap <= job.gap;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
         sender_gap_left <= gap_next;
      end
   end

   // Monitor: checks each response transaction and draws the receiver's stalls.
   always @(posedge clock) begin
      block_type want;
      int hold_next;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         receiver_hold <= 0;
         long_hold_done <= 1'b0;
      end else begin
         hold_next = receiver_hold;
         if (rsp_if.valid && rsp_if.ready) begin
            if (cipher_expected.size() == 0) begin
               error_count++;
               $display("tb: unexpected response at cycle %0d", cycle_count);
            end else begin
               want = cipher_expected.pop_front();
               if (rsp_if.data[127:64] !== want[127:64])
                  report_mismatch("result_upper", rsp_if.data[127:64], want[127:64]);
               if (rsp_if.data[63:0] !== want[63:0])
                  report_mismatch("result_lower", rsp_if.data[63:0], want[63:0]);
            end
            blocks_checked++;
            // One long stall fills the pipeline and pushes back on the sender.
            if (blocks_checked == 400 && !long_hold_done) begin
               hold_next = 300;
               long_hold_done <= 1'b1;
            end else if (sparse_gaps || $urandom_range(0, 3) == 0) begin
               hold_next = $urandom_range(0, 13);
            end else begin
               hold_next = 0;
            end
         end
         if (hold_next > 0) begin
            rsp_if.ready <= 1'b0;
            hold_next--;
         end else begin
            rsp_if.ready <= 1'b1;
         end
         receiver_hold <= hold_next;
      end
   end

   // Run-time limit.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 400000) begin
         $display("tb: timeout at cycle %0d", cycle_count);
         $display("tb: FAIL");
         $finish;
      end
   end

   task automatic queue_job(input action_type act, input block_type blk, input bit drain);
      cipher_job_type job;
      job.act = act;
      job.blk = blk;
      job.drain = drain;
      job.gap = sparse_gaps ? $urandom_range(0, 13) :
                ($urandom_range(0, 5) == 0 ? $urandom_range(0, 13) : 0);
      jobs_pending.push_back(job);
   endtask

   // Sample at the falling edge so that every clocked update has settled.
   task automatic wait_idle();
      @(negedge clock);
      while (jobs_pending.size() > 0 || req_if.valid || cipher_expected.size() > 0)
         @(negedge clock);
   endtask

   task automatic write_key_reg(input reg_index_type idx, input logic [63:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == REG_KEY_UPPER) key_hi = value;
      else key_lo = value;
   endtask

   task automatic random_phase(input int count);
      for (int i = 0; i < count; i++)
         queue_job(action_type'($urandom_range(0, 1)),
                   {$urandom, $urandom, $urandom, $urandom}, i == count / 2);
   endtask

   // Stimulus: directed vectors, then random phases under several keys.
   initial begin
      block_type fips_pt;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      req_if.valid = 1'b0;
      req_if.data = '0;
      rsp_if.ready = 1'b0;
      key_hi = '0;
      key_lo = '0;
      error_count = 0;
      blocks_sent = 0;
      blocks_checked = 0;
      cycle_count = 0;
      current_gap = 0;
      sparse_gaps = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part under the standard example key.
      write_key_reg(REG_KEY_UPPER, 64'h0001020304050607);
      write_key_reg(REG_KEY_LOWER, 64'h08090a0b0c0d0e0f);
      repeat (25) @(posedge clock);
      fips_pt = 128'h00112233445566778899aabbccddeeff;
      queue_job(ACTION_ENCRYPT, fips_pt, 1'b0);
      queue_job(ACTION_DECRYPT, 128'h69c4e0d86a7b0430d8cdb78070b4c55a, 1'b0);
      queue_job(ACTION_DECRYPT, fips_pt, 1'b0);
      queue_job(ACTION_ENCRYPT, '0, 1'b0);
      queue_job(ACTION_DECRYPT, '0, 1'b0);
      queue_job(ACTION_ENCRYPT, '1, 1'b0);
      queue_job(ACTION_DECRYPT, '1, 1'b0);
      queue_job(ACTION_ENCRYPT, {64{2'b10}}, 1'b0);
      queue_job(ACTION_DECRYPT, {64{2'b01}}, 1'b0);
      queue_job(ACTION_ENCRYPT, {64'hffffffffffffffff, 64'h0}, 1'b1);
      queue_job(ACTION_DECRYPT, {64'h0, 64'hffffffffffffffff}, 1'b0);
      queue_job(ACTION_ENCRYPT, 128'h1, 1'b0);
      queue_job(ACTION_DECRYPT, {1'b1, 127'h0}, 1'b0);
      wait_idle();

      // Extreme keys, each half rewritten alone, then random keys.
      for (int phase = 0; phase < 8; phase++) begin
         sparse_gaps = (phase % 3 == 1);
         case (phase)
            0: begin
               write_key_reg(REG_KEY_UPPER, '0);
               write_key_reg(REG_KEY_LOWER, '0);
            end
            1: begin
               write_key_reg(REG_KEY_UPPER, '1);
               write_key_reg(REG_KEY_LOWER, '1);
            end
            2: begin
               write_key_reg(REG_KEY_LOWER, {$urandom, $urandom});
            end
            3: begin
               write_key_reg(REG_KEY_UPPER, {$urandom, $urandom});
            end
            default: begin
               write_key_reg(REG_KEY_UPPER, {$urandom, $urandom});
               write_key_reg(REG_KEY_LOWER, {$urandom, $urandom});
            end
         endcase
         repeat (25) @(posedge clock);
         random_phase(225);
         wait_idle();
      end

      repeat (30) @(posedge clock);
      $display("tb: %0d blocks checked in both directions under nine key settings,",
               blocks_checked);
      $display("tb: including all-zero and all-one keys and single-half key updates.");
      if (error_count == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule

/* aes128_block_cipher.f */
src/aes_pkg.sv
src/aes_stream_if.sv
src/aes_round.sv
src/aes128_block_cipher.sv
sim/tb.sv
